// ----- sv/cst_pkg.sv -----
// Package: shared widths, word types and constants of the spline tangent block.
package cst_pkg;

  localparam int PT_W     = 32;
  localparam int DIFF_W   = 33;
  localparam int MAG_W    = 32;
  localparam int SQ_W     = 2 * MAG_W + 1;
  localparam int D_W      = 33;
  localparam int GAP_FRAC = 16;
  localparam int GAP_W    = 25;
  localparam int CFG_W    = 17;
  localparam int SUM_W    = GAP_W + 1;
  localparam int PROD_W   = GAP_W + SUM_W;
  localparam int LO_W     = 26;
  localparam int TERM_W   = MAG_W + PROD_W;
  localparam int NUM_W    = TERM_W + 3;
  localparam int M_W      = TERM_W + 2;
  localparam int Q_W      = 41;
  localparam int T_W      = 40;
  localparam int GAP_LAT  = 61;
  localparam int LANE_LAT = 48;
  localparam int PT_DLY   = GAP_LAT + 1;
  localparam int LATENCY  = GAP_LAT + 1 + LANE_LAT + 1;

  localparam logic [T_W-1:0] POS_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic [T_W-1:0] NEG_MAG = {1'b1, {(T_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] MIN_GAP_RST  = CFG_W'(7);
  localparam logic [CFG_W-1:0] FALLBACK_RST = CFG_W'(65536);

  typedef enum logic {
    REG_MIN_GAP  = 1'b0,
    REG_FALLBACK = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [PT_W-1:0] before_x;
    logic signed [PT_W-1:0] before_y;
    logic signed [PT_W-1:0] start_x;
    logic signed [PT_W-1:0] start_y;
    logic signed [PT_W-1:0] end_x;
    logic signed [PT_W-1:0] end_y;
    logic signed [PT_W-1:0] after_x;
    logic signed [PT_W-1:0] after_y;
  } in_word_t;

  typedef struct packed {
    logic signed [T_W-1:0] tangent_x_start;
    logic signed [T_W-1:0] tangent_x_end;
    logic signed [T_W-1:0] tangent_y_start;
    logic signed [T_W-1:0] tangent_y_end;
    logic                  saturated;
  } out_word_t;

  typedef struct packed {
    logic [T_W-1:0] tangent;
    logic           sat;
  } lane_out_t;

endpackage

// ----- sv/cst_gap.sv -----
// Knot gap lane: fourth root of the squared distance between two points, pipelined.
module cst_gap (
  input  logic                               clk,
  input  logic signed [cst_pkg::PT_W-1:0]    ax,
  input  logic signed [cst_pkg::PT_W-1:0]    ay,
  input  logic signed [cst_pkg::PT_W-1:0]    bx,
  input  logic signed [cst_pkg::PT_W-1:0]    by,
  output logic        [cst_pkg::GAP_W-1:0]   gap
);
  import cst_pkg::*;

  localparam int R1_BITS = D_W;
  localparam int R1_W    = 2 * R1_BITS;
  localparam int R2_BITS = GAP_W;
  localparam int R2_W    = 2 * R2_BITS;

  logic signed [DIFF_W-1:0] dxs, dys;
  logic [DIFF_W-1:0]        dxa, dya;
  logic [MAG_W-1:0]         mx, my;
  logic [2*MAG_W-1:0]       sqx, sqy;
  logic [SQ_W-1:0]          sq_sum;

  logic [R1_W-1:0]    r1_rem  [R1_BITS];
  logic [R1_BITS-1:0] r1_root [R1_BITS];
  logic [R2_W-1:0]    r2_rem  [R2_BITS];
  logic [R2_BITS-1:0] r2_root [R2_BITS];

  assign dxs = {bx[PT_W-1], bx} - {ax[PT_W-1], ax};
  assign dys = {by[PT_W-1], by} - {ay[PT_W-1], ay};
  assign dxa = dxs[DIFF_W-1] ? -dxs : dxs;
  assign dya = dys[DIFF_W-1] ? -dys : dys;

  always_ff @(posedge clk) begin
    mx     <= dxa[MAG_W-1:0];
    my     <= dya[MAG_W-1:0];
    sqx    <= mx * mx;
    sqy    <= my * my;
    sq_sum <= SQ_W'(sqx) + SQ_W'(sqy);
  end

  for (genvar j = 0; j < R1_BITS; j++) begin : g_sq1
    localparam int B = R1_BITS - 1 - j;
    logic [R1_W-1:0]    rem_in, trial;
    logic [R1_BITS-1:0] root_in;
    if (j == 0) begin : g_first
      assign rem_in  = R1_W'(sq_sum);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = r1_rem[j-1];
      assign root_in = r1_root[j-1];
    end
    assign trial = (R1_W'(root_in) << (B + 1)) | (R1_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        r1_rem[j]  <= rem_in - trial;
        r1_root[j] <= root_in | (R1_BITS'(1) << B);
      end else begin
        r1_rem[j]  <= rem_in;
        r1_root[j] <= root_in;
      end
    end
  end

  for (genvar j = 0; j < R2_BITS; j++) begin : g_sq2
    localparam int B = R2_BITS - 1 - j;
    logic [R2_W-1:0]    rem_in, trial;
    logic [R2_BITS-1:0] root_in;
    if (j == 0) begin : g_first
      assign rem_in  = R2_W'({r1_root[R1_BITS-1], {GAP_FRAC{1'b0}}});
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = r2_rem[j-1];
      assign root_in = r2_root[j-1];
    end
    assign trial = (R2_W'(root_in) << (B + 1)) | (R2_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        r2_rem[j]  <= rem_in - trial;
        r2_root[j] <= root_in | (R2_BITS'(1) << B);
      end else begin
        r2_rem[j]  <= rem_in;
        r2_root[j] <= root_in;
      end
    end
  end

  assign gap = r2_root[R2_BITS-1];

endmodule

// ----- sv/cst_lane.sv -----
// Tangent lane: exact numerator, pipelined rounding division and saturation.
module cst_lane (
  input  logic                               clk,
  input  logic signed [cst_pkg::DIFF_W-1:0]  u,
  input  logic signed [cst_pkg::DIFF_W-1:0]  v,
  input  logic signed [cst_pkg::DIFF_W-1:0]  w,
  input  logic        [cst_pkg::GAP_W-1:0]   ga,
  input  logic        [cst_pkg::GAP_W-1:0]   gb,
  output cst_pkg::lane_out_t                 res
);
  import cst_pkg::*;

  localparam int HI_W = PROD_W - LO_W;
  localparam int V_LO = PROD_W - 1 - GAP_W;
  localparam int OV_W = PROD_W + Q_W;

  logic signed [DIFF_W-1:0] u0, v0, w0;
  logic [GAP_W-1:0]         ga0, gb0;
  logic [SUM_W-1:0]         s0;

  logic [PROD_W-1:0]  p1, p2, den1;
  logic [MAG_W-1:0]   mu1, mv1, mw1;
  logic               su1, sv1, sw1;
  logic [DIFF_W-1:0]  ua, va, wa;

  logic [MAG_W+LO_W-1:0]  pul, pwl;
  logic [MAG_W+HI_W-1:0]  puh, pwh;
  logic [MAG_W+V_LO:0]    pvl;
  logic [MAG_W+V_LO:0]    pvh;
  logic [PROD_W-1:0]      den2;
  logic                   su2, sv2, sw2;

  logic [TERM_W-1:0]      tu, tv, tw;
  logic [PROD_W-1:0]      den3;
  logic                   su3, sv3, sw3;

  logic signed [NUM_W-1:0] eu, ev, ew;
  logic signed [NUM_W-1:0] num4;
  logic [PROD_W-1:0]       den4;

  logic [NUM_W-1:0]   mag;
  logic [M_W-1:0]     m5;
  logic               neg5, ovf5;
  logic [PROD_W-1:0]  den5;

  logic [PROD_W-1:0] drem [Q_W];
  logic [Q_W-1:0]    dq   [Q_W];
  logic [Q_W-1:0]    dlo  [Q_W];
  logic [PROD_W-1:0] dden [Q_W];
  logic              dneg [Q_W];
  logic              dovf [Q_W];

  logic [Q_W:0]      qr;
  logic [PROD_W:0]   rem2;
  logic [Q_W:0]      lim;

  always_ff @(posedge clk) begin
    u0  <= u;
    v0  <= v;
    w0  <= w;
    ga0 <= ga;
    gb0 <= gb;
    s0  <= SUM_W'(ga) + SUM_W'(gb);
  end

  assign ua = u0[DIFF_W-1] ? -u0 : u0;
  assign va = v0[DIFF_W-1] ? -v0 : v0;
  assign wa = w0[DIFF_W-1] ? -w0 : w0;

  always_ff @(posedge clk) begin
    p1   <= gb0 * s0;
    p2   <= ga0 * gb0;
    den1 <= ga0 * s0;
    mu1  <= ua[MAG_W-1:0];
    mv1  <= va[MAG_W-1:0];
    mw1  <= wa[MAG_W-1:0];
    su1  <= u0[DIFF_W-1];
    sv1  <= v0[DIFF_W-1];
    sw1  <= w0[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    pul  <= mu1 * p1[LO_W-1:0];
    puh  <= mu1 * p1[PROD_W-1:LO_W];
    pvl  <= mv1 * p2[V_LO:0];
    pvh  <= mv1 * p2[PROD_W-2:V_LO+1];
    pwl  <= mw1 * den1[LO_W-1:0];
    pwh  <= mw1 * den1[PROD_W-1:LO_W];
    den2 <= den1;
    su2  <= su1;
    sv2  <= sv1;
    sw2  <= sw1;
  end

  always_ff @(posedge clk) begin
    tu   <= (TERM_W'(puh) << LO_W) + TERM_W'(pul);
    tv   <= (TERM_W'(pvh) << (V_LO + 1)) + TERM_W'(pvl);
    tw   <= (TERM_W'(pwh) << LO_W) + TERM_W'(pwl);
    den3 <= den2;
    su3  <= su2;
    sv3  <= sv2;
    sw3  <= sw2;
  end

  assign eu = su3 ? -$signed(NUM_W'(tu)) : $signed(NUM_W'(tu));
  assign ev = sv3 ? -$signed(NUM_W'(tv)) : $signed(NUM_W'(tv));
  assign ew = sw3 ? -$signed(NUM_W'(tw)) : $signed(NUM_W'(tw));

  always_ff @(posedge clk) begin
    num4 <= eu - ev + ew;
    den4 <= den3;
  end

  assign mag = num4[NUM_W-1] ? -num4 : num4;

  always_ff @(posedge clk) begin
    neg5 <= num4[NUM_W-1];
    m5   <= mag[M_W-1:0];
    ovf5 <= OV_W'(mag[M_W-1:0]) >= {den4, {Q_W{1'b0}}};
    den5 <= den4;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [PROD_W-1:0] rem_in, den_in;
    logic [Q_W-1:0]    q_in, lo_in;
    logic              neg_in, ovf_in;
    logic [PROD_W:0]   trial, diff;
    if (j == 0) begin : g_first
      assign rem_in = PROD_W'(m5[M_W-1:Q_W]);
      assign lo_in  = m5[Q_W-1:0];
      assign q_in   = '0;
      assign den_in = den5;
      assign neg_in = neg5;
      assign ovf_in = ovf5;
    end else begin : g_next
      assign rem_in = drem[j-1];
      assign lo_in  = dlo[j-1];
      assign q_in   = dq[j-1];
      assign den_in = dden[j-1];
      assign neg_in = dneg[j-1];
      assign ovf_in = dovf[j-1];
    end
    assign trial = {rem_in, lo_in[Q_W-1]};
    assign diff  = trial - {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (trial >= {1'b0, den_in}) begin
        drem[j] <= diff[PROD_W-1:0];
        dq[j]   <= {q_in[Q_W-2:0], 1'b1};
      end else begin
        drem[j] <= trial[PROD_W-1:0];
        dq[j]   <= {q_in[Q_W-2:0], 1'b0};
      end
      dlo[j]  <= {lo_in[Q_W-2:0], 1'b0};
      dden[j] <= den_in;
      dneg[j] <= neg_in;
      dovf[j] <= ovf_in;
    end
  end

  assign rem2 = {drem[Q_W-1], 1'b0};
  assign qr   = {1'b0, dq[Q_W-1]} + ((rem2 >= {1'b0, dden[Q_W-1]}) ? (Q_W+1)'(1) : '0);
  assign lim  = (Q_W+1)'(NEG_MAG);

  always_ff @(posedge clk) begin
    if (dneg[Q_W-1]) begin
      if (dovf[Q_W-1] || qr > lim) begin
        res.tangent <= NEG_MAG;
        res.sat     <= 1'b1;
      end else begin
        res.tangent <= -qr[T_W-1:0];
        res.sat     <= 1'b0;
      end
    end else begin
      if (dovf[Q_W-1] || qr > (Q_W+1)'(POS_MAX)) begin
        res.tangent <= POS_MAX;
        res.sat     <= 1'b1;
      end else begin
        res.tangent <= qr[T_W-1:0];
        res.sat     <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/centripetal_spline_tangents.sv -----
// Top level: gap lanes, gap replacement, four tangent lanes and the result merge.
// Takes one word of four control points on every cycle (busy stays low) and delivers its
// tangents for exactly one cycle under done; the pipeline depth is set by the two
// bit-per-stage square roots of the gap lanes and the bit-per-stage division of the
// tangent lanes. The receiver cannot stall, so results must be taken as they appear.
// Write min_gap and fallback_gap only while no word is in flight.
module centripetal_spline_tangents (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  cst_pkg::in_word_t                points,
  output logic                             done,
  output cst_pkg::out_word_t               result,
  input  logic                             wr_en,
  input  cst_pkg::reg_index_t              wr_index,
  input  logic [cst_pkg::CFG_W-1:0]        wr_data
);
  import cst_pkg::*;

  logic [CFG_W-1:0]   min_gap, fallback_gap;
  logic [LATENCY-1:0] vld;
  in_word_t           tap [PT_DLY];
  in_word_t           pd;

  logic [GAP_W-1:0] g0, g1, g2;
  logic [GAP_W-1:0] g0f, g1f, g2f;
  logic [GAP_W-1:0] g1_next, g0_next, g2_next;
  logic [GAP_W-1:0] thr, fb;

  lane_out_t xs, xe, ys, ye;

  assign busy = 1'b0;
  assign done = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap      <= MIN_GAP_RST;
      fallback_gap <= FALLBACK_RST;
      vld          <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
      if (wr_en) begin
        unique case (wr_index)
          REG_MIN_GAP:  min_gap      <= wr_data;
          REG_FALLBACK: fallback_gap <= wr_data;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tap[0] <= points;
    for (int i = 1; i < PT_DLY; i++) begin
      tap[i] <= tap[i-1];
    end
  end

  cst_gap u_gap0 (.clk(clk), .ax(points.before_x), .ay(points.before_y),
                  .bx(points.start_x), .by(points.start_y), .gap(g0));
  cst_gap u_gap1 (.clk(clk), .ax(points.start_x), .ay(points.start_y),
                  .bx(points.end_x), .by(points.end_y), .gap(g1));
  cst_gap u_gap2 (.clk(clk), .ax(points.end_x), .ay(points.end_y),
                  .bx(points.after_x), .by(points.after_y), .gap(g2));

  assign thr     = GAP_W'(min_gap);
  assign fb      = (fallback_gap == '0) ? GAP_W'(1) : GAP_W'(fallback_gap);
  assign g1_next = (g1 == '0 || g1 < thr) ? fb : g1;
  assign g0_next = (g0 == '0 || g0 < thr) ? g1_next : g0;
  assign g2_next = (g2 == '0 || g2 < thr) ? g1_next : g2;

  always_ff @(posedge clk) begin
    g0f <= g0_next;
    g1f <= g1_next;
    g2f <= g2_next;
  end

  assign pd = tap[PT_DLY-1];

  cst_lane u_xs (.clk(clk),
    .u({pd.start_x[PT_W-1], pd.start_x} - {pd.before_x[PT_W-1], pd.before_x}),
    .v({pd.end_x[PT_W-1], pd.end_x} - {pd.before_x[PT_W-1], pd.before_x}),
    .w({pd.end_x[PT_W-1], pd.end_x} - {pd.start_x[PT_W-1], pd.start_x}),
    .ga(g0f), .gb(g1f), .res(xs));
  cst_lane u_xe (.clk(clk),
    .u({pd.after_x[PT_W-1], pd.after_x} - {pd.end_x[PT_W-1], pd.end_x}),
    .v({pd.after_x[PT_W-1], pd.after_x} - {pd.start_x[PT_W-1], pd.start_x}),
    .w({pd.end_x[PT_W-1], pd.end_x} - {pd.start_x[PT_W-1], pd.start_x}),
    .ga(g2f), .gb(g1f), .res(xe));
  cst_lane u_ys (.clk(clk),
    .u({pd.start_y[PT_W-1], pd.start_y} - {pd.before_y[PT_W-1], pd.before_y}),
    .v({pd.end_y[PT_W-1], pd.end_y} - {pd.before_y[PT_W-1], pd.before_y}),
    .w({pd.end_y[PT_W-1], pd.end_y} - {pd.start_y[PT_W-1], pd.start_y}),
    .ga(g0f), .gb(g1f), .res(ys));
  cst_lane u_ye (.clk(clk),
    .u({pd.after_y[PT_W-1], pd.after_y} - {pd.end_y[PT_W-1], pd.end_y}),
    .v({pd.after_y[PT_W-1], pd.after_y} - {pd.start_y[PT_W-1], pd.start_y}),
    .w({pd.end_y[PT_W-1], pd.end_y} - {pd.start_y[PT_W-1], pd.start_y}),
    .ga(g2f), .gb(g1f), .res(ye));

  always_ff @(posedge clk) begin
    result.tangent_x_start <= xs.tangent;
    result.tangent_x_end   <= xe.tangent;
    result.tangent_y_start <= ys.tangent;
    result.tangent_y_end   <= ye.tangent;
    result.saturated       <= xs.sat | xe.sat | ys.sat | ye.sat;
  end

endmodule

// ----- tb/sv/tb_centripetal_spline_tangents.sv -----
// Testbench: spline tangent block against a bit-true tangent predictor.
module tb_centripetal_spline_tangents;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  class tangent_board;
    logic [CFG_W-1:0] min_gap;
    logic [CFG_W-1:0] fallback_gap;
    out_word_t        tangents_due[$];
    int               fails;
    int               checked;
    int               clipped;

    function new();
      min_gap = MIN_GAP_RST;
      fallback_gap = FALLBACK_RST;
      fails = 0;
      checked = 0;
      clipped = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_MIN_GAP) min_gap = val;
      else fallback_gap = val;
    endfunction

    function logic [127:0] root(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function logic [63:0] gap_of(logic signed [63:0] ax, logic signed [63:0] ay,
                                 logic signed [63:0] bx, logic signed [63:0] by);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [127:0] sq;
      logic [127:0] d;
      dx = bx - ax;
      dy = by - ay;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      d = root(sq);
      return 64'(root(d << 16));
    endfunction

    function logic [T_W-1:0] tangent(logic signed [63:0] u, logic signed [63:0] v,
                                     logic signed [63:0] w, logic [63:0] ga,
                                     logic [63:0] gb, inout logic sat);
      logic [63:0] s;
      logic signed [191:0] su, sv, sw, fu, fv, fw, num;
      logic [191:0] m, q, r, den;
      s = ga + gb;
      su = u; sv = v; sw = w;
      fu = gb * s; fv = ga * gb; fw = ga * s;
      den = ga * s;
      num = su * fu - sv * fv + sw * fw;
      m = (num < 0) ? -num : num;
      q = m / den;
      r = m % den;
      if (2 * r >= den) q = q + 1;
      if (num < 0) begin
        if (q > 192'(NEG_MAG)) begin
          sat = 1'b1;
          return NEG_MAG;
        end
        return -q[T_W-1:0];
      end
      if (q > 192'(POS_MAX)) begin
        sat = 1'b1;
        return POS_MAX;
      end
      return q[T_W-1:0];
    endfunction

    function void note_points(in_word_t p);
      logic signed [63:0] x0, y0, x1, y1, x2, y2, x3, y3;
      logic [63:0] g0, g1, g2;
      logic sat;
      out_word_t o;
      x0 = p.before_x; y0 = p.before_y; x1 = p.start_x; y1 = p.start_y;
      x2 = p.end_x; y2 = p.end_y; x3 = p.after_x; y3 = p.after_y;
      g0 = gap_of(x0, y0, x1, y1);
      g1 = gap_of(x1, y1, x2, y2);
      g2 = gap_of(x2, y2, x3, y3);
      if (g1 == 0 || g1 < 64'(min_gap)) g1 = (fallback_gap == 0) ? 64'd1 : 64'(fallback_gap);
      if (g0 == 0 || g0 < 64'(min_gap)) g0 = g1;
      if (g2 == 0 || g2 < 64'(min_gap)) g2 = g1;
      sat = 1'b0;
      o.tangent_x_start = tangent(x1 - x0, x2 - x0, x2 - x1, g0, g1, sat);
      o.tangent_x_end   = tangent(x3 - x2, x3 - x1, x2 - x1, g2, g1, sat);
      o.tangent_y_start = tangent(y1 - y0, y2 - y0, y2 - y1, g0, g1, sat);
      o.tangent_y_end   = tangent(y3 - y2, y3 - y1, y2 - y1, g2, g1, sat);
      o.saturated = sat;
      tangents_due.push_back(o);
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      if (tangents_due.size() == 0) begin
        $error("result with nothing outstanding: %h", a);
        fails++;
        return;
      end
      e = tangents_due.pop_front();
      checked++;
      if (a.saturated === 1'b1) clipped++;
      if (a.tangent_x_start !== e.tangent_x_start) begin
        $error("tangent_x_start exp %h got %h", e.tangent_x_start, a.tangent_x_start);
        fails++;
      end
      if (a.tangent_x_end !== e.tangent_x_end) begin
        $error("tangent_x_end exp %h got %h", e.tangent_x_end, a.tangent_x_end);
        fails++;
      end
      if (a.tangent_y_start !== e.tangent_y_start) begin
        $error("tangent_y_start exp %h got %h", e.tangent_y_start, a.tangent_y_start);
        fails++;
      end
      if (a.tangent_y_end !== e.tangent_y_end) begin
        $error("tangent_y_end exp %h got %h", e.tangent_y_end, a.tangent_y_end);
        fails++;
      end
      if (a.saturated !== e.saturated) begin
        $error("saturated exp %b got %b", e.saturated, a.saturated);
        fails++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  in_word_t         points = '0;
  logic             done;
  out_word_t        result;
  logic             wr_en = 1'b0;
  reg_index_t       wr_index = REG_MIN_GAP;
  logic [CFG_W-1:0] wr_data = '0;

  tangent_board board = new();
  int quiet_cycles = 0;
  int words_sent = 0;
  int idle_pct = 15;

  centripetal_spline_tangents u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .points(points),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) board.set_reg(wr_index, wr_data);
      if (start && !busy) begin
        board.note_points(points);
      end
      if (done) begin
        board.check_result(result);
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("centripetal_spline_tangents verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t p);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    points <= p;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (board.tangents_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    int k;
    k = $urandom_range(20, 0);
    if ($urandom_range(9, 0) == 0) return base;
    return base + 32'($urandom_range((1 << k), 0)) - 32'($urandom_range((1 << k), 0));
  endfunction

  function automatic in_word_t rand_word();
    in_word_t p;
    logic [31:0] bx, by;
    if ($urandom_range(3, 0) == 0) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      bx = $urandom;
      by = $urandom;
      p.before_x = near(bx); p.before_y = near(by);
      p.start_x = near(bx); p.start_y = near(by);
      p.end_x = near(bx); p.end_y = near(by);
      p.after_x = near(bx); p.after_y = near(by);
      if ($urandom_range(7, 0) == 0) begin
        p.start_x = p.end_x;
        p.start_y = p.end_y;
      end
    end
    return p;
  endfunction

  task automatic run_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_word('0);
    send_word({mn, mn, mx, mx, mn, mn, mx, mx});
    send_word({mx, mx, mn, mn, mx, mx, mn, mn});
    send_word({mn, mx, mx, mn, mn, mx, mx, mn});
    send_word({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h1});
    send_word({32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h20000, 32'h0});
    send_word({32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h20000, 32'h0});
    send_word({32'h0, 32'h0, 32'h10000, 32'h0, 32'h20000, 32'h0, 32'h20000, 32'h0});
    send_word({32'h5, 32'h0, 32'h0, 32'h0, 32'h3, 32'h0, 32'h4, 32'h0});
    send_word({mn, mn, 32'h0, 32'h0, 32'h1, 32'h1, mx, mx});
    send_word({32'h0, 32'h0, mx, 32'h0, mx, 32'h1, 32'h0, 32'h1});
    send_word({32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
               32'hFFFF_0000, 32'h0000_FFFF, 32'h1234_5678, 32'h8765_4321});
  endtask

  initial begin
    logic [CFG_W-1:0] min_set [5];
    logic [CFG_W-1:0] fb_set [5];
    min_set = '{17'd7, 17'd0, 17'd65536, 17'd0, 17'd300};
    fb_set  = '{17'd65536, 17'd0, 17'd65536, 17'd1, 17'd4097};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MIN_GAP, min_set[ph]);
      write_reg(REG_FALLBACK, fb_set[ph]);
      if (ph == 1) run_directed();
      idle_pct = (ph == 2) ? 0 : 15;
      repeat (265) send_word(rand_word());
    end
    start <= 1'b0;
    while (board.tangents_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.tangents_due.size() != 0) begin
      $error("%0d results never arrived", board.tangents_due.size());
      board.fails++;
    end
    $display("Sent %0d point quadruples over five register settings, checked %0d results",
             words_sent, board.checked);
    $display("(%0d clipped), %0d mismatches", board.clipped, board.fails);
    if (board.fails == 0) begin
      $display("centripetal_spline_tangents verification clean");
    end else begin
      $display("centripetal_spline_tangents verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/cst_pkg.sv
sv/cst_gap.sv
sv/cst_lane.sv
sv/centripetal_spline_tangents.sv
tb/sv/tb_centripetal_spline_tangents.sv
